/* src/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define PTCM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ptcm check failed");

// Antecedent at an edge implies consequent at the next edge.
`define PTCM_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptcm check failed");

`endif

/* src/ptcm_pkg.sv */
// Shared types, constants and fixed lookup tables for the pedal torque map.
// No dependencies.
`default_nettype none
package ptcm_pkg;

	localparam int LOG_TABLE_BITS = 8;
	localparam int TBL_SIZE = 1 << LOG_TABLE_BITS;
	localparam int DATA_W = 16;
	localparam int ADDR_W = 5;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;

	typedef enum logic [2:0] {
		REG_FULL_SCALE = 3'd0,
		REG_LIMIT      = 3'd1,
		REG_GAIN       = 3'd2,
		REG_CEILING    = 3'd3,
		REG_MODE       = 3'd4,
		REG_EXPONENT   = 3'd5
	} reg_idx_t;

	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_POWER  = 2'd2;

	// What the back end does with an item.
	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_LINEAR,
		KIND_POWER,
		KIND_CEIL
	} kind_t;

	typedef struct packed {
		logic [DATA_W-1:0] scaled;
		kind_t             kind;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] full_scale;
		logic [DATA_W-1:0] limit;
		logic [DATA_W-1:0] gain;
		logic [DATA_W-1:0] ceiling;
		logic [1:0]        mode;
		logic [DATA_W-1:0] exponent;
	} cfg_t;

	typedef logic [15:0] log_tbl_t [TBL_SIZE];
	typedef logic [16:0] exp_tbl_t [TBL_SIZE];

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] bitv;
		v = v_in;
		r = 64'd0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 64'd0) begin
			if (v >= r + bitv) begin
				v = v - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	// log2(1 + i/2^B) in Q0.16 by repeated squaring of a Q30 value.
	function automatic log_tbl_t build_log();
		log_tbl_t t;
		logic [63:0] x;
		logic [15:0] val;
		for (int i = 0; i < TBL_SIZE; i++) begin
			x = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
			val = 16'd0;
			for (int k = 0; k < 16; k++) begin
				x = (x * x) >> 30;
				val = {val[14:0], 1'b0};
				if (x >= (64'd1 << 31)) begin
					x = x >> 1;
					val[0] = 1'b1;
				end
			end
			t[i] = val;
		end
		return t;
	endfunction

	// 2^(-j/2^B) in Q1.16, built from successive square roots in Q30.
	function automatic exp_tbl_t build_exp();
		exp_tbl_t t;
		logic [63:0] roots [LOG_TABLE_BITS+1];
		logic [63:0] acc;
		roots[0] = 64'd1 << 29;
		for (int k = 1; k <= LOG_TABLE_BITS; k++)
			roots[k] = isqrt64(roots[k-1] << 30);
		for (int i = 0; i < TBL_SIZE; i++) begin
			acc = 64'd1 << 30;
			for (int k = 1; k <= LOG_TABLE_BITS; k++)
				if (((i >> (LOG_TABLE_BITS - k)) & 1) != 0)
					acc = (acc * roots[k]) >> 30;
			t[i] = 17'(acc >> 14);
		end
		return t;
	endfunction

	localparam log_tbl_t LOG_TBL = build_log();
	localparam exp_tbl_t EXP_TBL = build_exp();

endpackage
`default_nettype wire

/* src/ptcm_front.sv */
// Front end: deadzone removal, gain, saturation and curve classification.
// Depends on ptcm_pkg.
`default_nettype none
module ptcm_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ptcm_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [15:0]   pedal_sample,
	input  wire logic          fifo_full,
	output logic               push,
	output ptcm_pkg::item_t    push_item
);
	import ptcm_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic [16:0] diff;
	logic [31:0] prod;
	logic [15:0] scaled;
	kind_t       kind;

	assign in_stall  = valid_s1 && fifo_full;
	assign push      = valid_s1 && !fifo_full;
	assign push_item = item_s1;

	always_comb begin
		diff = {1'b0, pedal_sample} - {1'b0, cfg.limit};
		prod = 32'(diff[15:0]) * 32'(cfg.gain);
		if (pedal_sample <= cfg.limit)
			scaled = '0;
		else if (prod[31:28] != 4'd0)
			scaled = '1;
		else
			scaled = prod[27:12];
		case (cfg.mode)
			MODE_LINEAR: kind = KIND_LINEAR;
			MODE_POWER:  kind = (cfg.exponent == '0) ? KIND_CEIL : KIND_POWER;
			default:     kind = KIND_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.scaled <= scaled;
			item_s1.kind   <= kind;
		end
	end

endmodule
`default_nettype wire

/* src/ptcm_fifo.sv */
// Short item queue between the front and back ends.
// Depends on ptcm_pkg.
`default_nettype none
module ptcm_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ptcm_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                not_empty,
	output ptcm_pkg::item_t     pop_item
);
	import ptcm_pkg::*;

	item_t                 slots [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;

	assign full      = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = slots[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slots[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

/* src/ptcm_div.sv */
// Pipelined restoring divider, stage 0 then one quotient bit per stage, 32 by 16 bits.
// Depends on ptcm_pkg.
`default_nettype none
module ptcm_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [31:0]   num,
	input  wire logic [15:0]   den,
	input  wire ptcm_pkg::kind_t in_kind,
	input  wire logic [15:0]   in_res,
	output logic               out_valid,
	output logic [15:0]        quot,
	output logic               ovf,
	output ptcm_pkg::kind_t    out_kind
);
	import ptcm_pkg::*;

	localparam int STEPS = DATA_W;

	logic        valid_q [STEPS+1];
	logic [15:0] rem_q   [STEPS+1];
	logic [15:0] low_q   [STEPS+1];
	logic [15:0] quot_q  [STEPS+1];
	logic        ovf_q   [STEPS+1];
	kind_t       kind_q  [STEPS+1];

	// Stage 0 splits the numerator; quotient overflows 16 bits when hi >= den.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q[0] <= 1'b0;
		else if (en)
			valid_q[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= num[31:16];
			low_q[0]  <= num[15:0];
			quot_q[0] <= '0;
			ovf_q[0]  <= (num[31:16] >= den);
			kind_q[0] <= (in_kind == KIND_LINEAR && in_res != 16'd0) ? KIND_LINEAR : in_kind;
		end
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic [16:0] trial;
		logic        ge;
		assign trial = {rem_q[g], low_q[g][15]};
		assign ge    = (trial >= {1'b0, den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_q[g+1] <= 1'b0;
			else if (en)
				valid_q[g+1] <= valid_q[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g+1]  <= ge ? 16'(trial - {1'b0, den}) : trial[15:0];
				low_q[g+1]  <= {low_q[g][14:0], 1'b0};
				quot_q[g+1] <= {quot_q[g][14:0], ge};
				ovf_q[g+1]  <= ovf_q[g];
				kind_q[g+1] <= kind_q[g];
			end
		end
	end

	assign out_valid = valid_q[STEPS];
	assign quot      = quot_q[STEPS];
	assign ovf       = ovf_q[STEPS];
	assign out_kind  = kind_q[STEPS];

endmodule
`default_nettype wire

/* src/ptcm_back.sv */
// Back end: divide by full scale, power curve via log/exp tables, output register.
// Depends on ptcm_pkg and ptcm_div.
`default_nettype none
module ptcm_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ptcm_pkg::cfg_t cfg,
	input  wire logic           fifo_not_empty,
	input  wire ptcm_pkg::item_t fifo_item,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [15:0]         torque_request
);
	import ptcm_pkg::*;

	localparam int B = LOG_TABLE_BITS;

	logic        advance;
	logic [15:0] fs_eff;
	logic [15:0] x_clamp;

	logic        valid_s1;
	logic [31:0] num_s1;
	kind_t       kind_s1;

	logic        dvalid;
	logic [15:0] dquot;
	logic        dovf;
	kind_t       dkind;

	logic        valid_s2, valid_s3, valid_s4;
	kind_t       kind_s2, kind_s3, kind_s4;
	logic [15:0] res_s2, res_s3, res_s4;
	logic        zero_s2, zero_s3;
	logic [20:0] n_s2;
	logic [8:0]  q_s3;
	logic [B-1:0] j_s3;
	logic [16:0] shaped_s4;

	logic        out_valid_q;
	logic [15:0] torque_q;

	logic [3:0]  lead;
	logic [15:0] norm;
	logic [B-1:0] idx;
	logic [20:0] n_next;
	logic [36:0] e_full;
	logic [32:0] out_prod;
	logic [15:0] out_next;

	assign advance        = !out_valid_q || !out_stall;
	assign pop            = advance && fifo_not_empty;
	assign out_valid      = out_valid_q;
	assign torque_request = torque_q;

	assign fs_eff  = (cfg.full_scale == '0) ? 16'd1 : cfg.full_scale;
	assign x_clamp = (fifo_item.scaled < fs_eff) ? fifo_item.scaled : fs_eff;

	// Stage 1: numerator for the shared divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= fifo_not_empty;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s1 <= fifo_item.kind;
			case (fifo_item.kind)
				KIND_LINEAR: num_s1 <= 32'(fifo_item.scaled) * 32'(cfg.ceiling);
				KIND_POWER:  num_s1 <= {x_clamp, 16'd0};
				default:     num_s1 <= '0;
			endcase
		end
	end

	ptcm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.in_valid (valid_s1),
		.num      (num_s1),
		.den      (fs_eff),
		.in_kind  (kind_s1),
		.in_res   (num_s1[31:16] | num_s1[15:0]),
		.out_valid(dvalid),
		.quot     (dquot),
		.ovf      (dovf),
		.out_kind (dkind)
	);

	// Stage 2: -log2 of the Q0.16 fraction.
	always_comb begin
		lead = '0;
		for (int b = 0; b < 16; b++)
			if (dquot[b])
				lead = 4'(b);
		norm   = dquot << (4'd15 - lead);
		idx    = norm[14 -: B];
		n_next = 21'((21'(16) - 21'(lead)) << 16) - 21'(LOG_TBL[idx]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s2 <= dvalid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s2 <= dkind;
			res_s2  <= dovf ? 16'hFFFF : dquot;
			zero_s2 <= !dovf && (dquot == '0);
			n_s2    <= dovf ? '0 : n_next;
		end
	end

	// Stage 3: scale by the exponent.
	assign e_full = 37'(n_s2) * 37'(cfg.exponent);

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s3 <= kind_s2;
			res_s3  <= res_s2;
			zero_s3 <= zero_s2;
			q_s3    <= e_full[36:28];
			j_s3    <= e_full[27 -: B];
		end
	end

	// Stage 4: exp2 lookup and shift by the integer part.
	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s4 <= kind_s3;
			res_s4  <= res_s3;
			if (zero_s3 || q_s3 >= 9'd32)
				shaped_s4 <= '0;
			else
				shaped_s4 <= EXP_TBL[j_s3] >> q_s3[4:0];
		end
	end

	// Output: select the result by kind, apply the ceiling to the power curve and register.
	always_comb begin
		out_prod = 33'(shaped_s4) * 33'(cfg.ceiling);
		case (kind_s4)
			KIND_LINEAR: out_next = res_s4;
			KIND_POWER:  out_next = out_prod[31:16];
			KIND_CEIL:   out_next = cfg.ceiling;
			default:     out_next = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance)
			torque_q <= out_next;
	end

endmodule
`default_nettype wire

/* src/pedal_torque_curve_map_unit.sv */
// Top level of the pedal torque curve map: register port, front, queue, back.
// Depends on ptcm_pkg, ptcm_front, ptcm_fifo, ptcm_back.
//
// Usage:
//  - Input channel: in_valid / in_stall with pedal_sample; one item per sample.
//  - Output channel: out_valid / out_stall with torque_request; one item per input.
//  - Registers on an APB-style port at byte address 4*index; pready is tied high.
//    Write them only while no item is in flight.
//  - Throughput: one item per cycle sustained while the receiver does not stall.
//    Pipeline: front register, queue, numerator stage, 17 divider stages (a split
//    stage, then one quotient bit per stage for the 32/16 division by full scale),
//    three curve stages and the output register.
//  - Receiver stall while out_valid is high freezes the whole back end; the four-entry queue keeps the
//    front taking items until it fills, then in_stall rises.
//  - Reset clears all valid bits and loads register defaults; no table sweep
//    is needed since the log/exp tables are constant.
`default_nettype none
module pedal_torque_curve_map_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ptcm_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [15:0]                   pedal_sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [15:0]                   torque_request
);
	import ptcm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	logic  push, fifo_full, pop, fifo_not_empty;
	item_t push_item, pop_item;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Register file; writes beyond the list fall to the default arm.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_scale <= 16'hFFFF;
			cfg_q.limit      <= 16'd0;
			cfg_q.gain       <= 16'd4096;
			cfg_q.ceiling    <= 16'd0;
			cfg_q.mode       <= 2'd0;
			cfg_q.exponent   <= 16'd4096;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FULL_SCALE: cfg_q.full_scale <= pwdata[15:0];
				REG_LIMIT:      cfg_q.limit      <= pwdata[15:0];
				REG_GAIN:       cfg_q.gain       <= pwdata[15:0];
				REG_CEILING:    cfg_q.ceiling    <= pwdata[15:0];
				REG_MODE:       cfg_q.mode       <= pwdata[1:0];
				REG_EXPONENT:   cfg_q.exponent   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FULL_SCALE: prdata = {16'd0, cfg_q.full_scale};
			REG_LIMIT:      prdata = {16'd0, cfg_q.limit};
			REG_GAIN:       prdata = {16'd0, cfg_q.gain};
			REG_CEILING:    prdata = {16'd0, cfg_q.ceiling};
			REG_MODE:       prdata = {30'd0, cfg_q.mode};
			REG_EXPONENT:   prdata = {16'd0, cfg_q.exponent};
			default:        prdata = '0;
		endcase
	end

	ptcm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pedal_sample(pedal_sample),
		.fifo_full   (fifo_full),
		.push        (push),
		.push_item   (push_item)
	);

	ptcm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (fifo_full),
		.pop      (pop),
		.not_empty(fifo_not_empty),
		.pop_item (pop_item)
	);

	ptcm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.fifo_not_empty(fifo_not_empty),
		.fifo_item     (pop_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.torque_request(torque_request)
	);

endmodule
`default_nettype wire

/* src/ptcm_checker.sv */
// Port-level checks for the pedal torque curve map, bound to the top level.
// Depends on ptcm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ptcm_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        psel,
	input wire logic                        penable,
	input wire logic                        pwrite,
	input wire logic [ptcm_pkg::ADDR_W-1:0] paddr,
	input wire logic [31:0]                 pwdata,
	input wire logic [31:0]                 prdata,
	input wire logic                        pready,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [15:0]                 torque_request
);
	import ptcm_pkg::*;

	logic wr_fs, wr_mode;
	assign wr_fs   = psel && penable && pwrite && (paddr[4:2] == REG_FULL_SCALE);
	assign wr_mode = psel && penable && pwrite && (paddr[4:2] == REG_MODE);

	`PTCM_IMPLY(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(torque_request))
	`PTCM_ASSERT(a_ready_high, clk, arst_n, pready)
	`PTCM_IMPLY(a_fs_readback, clk, arst_n, wr_fs, (paddr[4:2] != REG_FULL_SCALE) || (prdata == {16'd0, $past(pwdata[15:0])}))
	`PTCM_IMPLY(a_mode_readback, clk, arst_n, wr_mode, (paddr[4:2] != REG_MODE) || (prdata == {30'd0, $past(pwdata[1:0])}))

endmodule

bind pedal_torque_curve_map_unit ptcm_checker u_ptcm_checker (.*);
`default_nettype wire

/* verif/pedal_torque_curve_map_unit_tb.sv */
// Testbench for pedal_torque_curve_map_unit: programs the register port, drives
// pedal samples on the item channels, predicts each torque request, compares.
// Depends on ptcm_pkg and the RTL of pedal_torque_curve_map_unit.
`default_nettype none
module pedal_torque_curve_map_unit_tb;
	import ptcm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] pedal_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] torque_request;

	pedal_torque_curve_map_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .pedal_sample(pedal_sample),
		.out_valid(out_valid), .out_stall(out_stall), .torque_request(torque_request)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the register file, as the block should hold it.
	logic [15:0] full_scale_q = 16'd65535;
	logic [15:0] limit_q = 16'd0;
	logic [15:0] gain_q = 16'd4096;
	logic [15:0] ceiling_q = 16'd0;
	logic [1:0] mode_q = 2'd0;
	logic [15:0] exponent_q = 16'd4096;

	// Tables built here from first principles, not taken from the package.
	logic [15:0] log2_rom [TBL_SIZE];
	logic [31:0] exp2_rom [TBL_SIZE];

	logic [15:0] torque_expected [$];
	int mismatch_count = 0;
	int result_count = 0;
	int cycle_count = 0;
	bit random_stall_en = 1'b0;
	bit input_gap_en = 1'b0;
	int hold_off_cycles = 0;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
		logic [63:0] v, r, b;
		v = v_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic fill_roms();
		logic [63:0] roots [LOG_TABLE_BITS+1];
		logic [63:0] x, acc;
		logic [15:0] val;
		roots[0] = 64'd1 << 29;
		for (int k = 1; k <= LOG_TABLE_BITS; k++)
			roots[k] = int_sqrt(roots[k-1] << 30);
		for (int i = 0; i < TBL_SIZE; i++) begin
			x = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
			val = 0;
			for (int k = 0; k < 16; k++) begin
				x = (x * x) >> 30;
				val = val << 1;
				if (x >= (64'd1 << 31)) begin
					x = x >> 1;
					val[0] = 1'b1;
				end
			end
			log2_rom[i] = val;
			acc = 64'd1 << 30;
			for (int k = 1; k <= LOG_TABLE_BITS; k++)
				if ((i >> (LOG_TABLE_BITS - k)) & 1)
					acc = (acc * roots[k]) >> 30;
			exp2_rom[i] = 32'(acc >> 14);
		end
	endtask

	// Fraction ^ exponent scaled onto the ceiling, via log2/exp2 tables.
	function automatic logic [15:0] shape_power(input logic [15:0] scaled, input logic [31:0] fs);
		logic [31:0] x, frac, p, idx, q, j;
		logic [63:0] n, e;
		x = (scaled < fs) ? scaled : fs;
		frac = 32'((64'(x) << 16) / fs);
		if (exponent_q == 0) return ceiling_q;
		if (frac == 0) return 16'd0;
		if (frac >= 65536) n = 0;
		else begin
			p = 15;
			while (frac[p] == 1'b0) p--;
			idx = (((frac << (15 - p)) & 32'h7FFF) >> (15 - LOG_TABLE_BITS)) & (TBL_SIZE - 1);
			n = 64'(16 - p) * 65536 - log2_rom[idx];
		end
		e = (n * exponent_q) >> 12;
		if ((e >> 16) >= 32) return 16'd0;
		q = 32'(e >> 16);
		j = ((e & 64'hFFFF) >> (16 - LOG_TABLE_BITS)) & (TBL_SIZE - 1);
		return 16'(((64'(exp2_rom[j] >> q)) * ceiling_q) >> 16);
	endfunction

	function automatic logic [15:0] predict_torque(input logic [15:0] s);
		logic [31:0] fs;
		logic [63:0] t;
		logic [15:0] scaled;
		fs = (full_scale_q == 0) ? 32'd1 : 32'(full_scale_q);
		scaled = 0;
		if (s > limit_q) begin
			t = (64'(s - limit_q) * gain_q) >> 12;
			scaled = (t > 65535) ? 16'hFFFF : 16'(t);
		end
		if (mode_q == MODE_LINEAR) begin
			t = (64'(scaled) * ceiling_q) / fs;
			return (t > 65535) ? 16'hFFFF : 16'(t);
		end
		if (mode_q == MODE_POWER) return shape_power(scaled, fs);
		return 16'd0;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		mismatch_count++;
	endtask

	// Register write: setup phase, access phase, then idle.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FULL_SCALE: full_scale_q = value[15:0];
			REG_LIMIT:      limit_q = value[15:0];
			REG_GAIN:       gain_q = value[15:0];
			REG_CEILING:    ceiling_q = value[15:0];
			REG_MODE:       mode_q = value[1:0];
			REG_EXPONENT:   exponent_q = value[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_curve(input logic [15:0] fs, input logic [15:0] lim,
			input logic [15:0] gn, input logic [15:0] ceil, input logic [1:0] md,
			input logic [15:0] ex);
		write_reg(REG_FULL_SCALE, {16'hA5A5, fs});
		write_reg(REG_LIMIT, 32'(lim));
		write_reg(REG_GAIN, 32'(gn));
		write_reg(REG_CEILING, 32'(ceil));
		write_reg(REG_MODE, 32'(md));
		write_reg(REG_EXPONENT, 32'(ex));
	endtask

	// Offer one sample until accepted; prediction is queued on acceptance.
	// in_valid stays high into the next item unless an idle gap follows.
	task automatic send_sample(input logic [15:0] s);
		if (input_gap_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pedal_sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		torque_expected.push_back(predict_torque(s));
	endtask

	// Wait for every expected item, then let the pipeline settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (torque_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random sample biased toward the deadzone edge and the extremes.
	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'(limit_q + $urandom_range(0, 3));
			2: return 16'($urandom_range(65528, 65535));
			3: return 16'($urandom_range(0, 7));
			default: return 16'($urandom_range(0, full_scale_q + 64 > 65535 ? 65535
				: full_scale_q + 64));
		endcase
	endfunction

	// Result checker: compares each accepted item with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (torque_expected.size() == 0)
				report_mismatch("unexpected item", torque_request, 16'd0);
			else begin
				logic [15:0] want;
				want = torque_expected.pop_front();
				if (torque_request !== want)
					report_mismatch("torque_request", torque_request, want);
			end
		end
	end

	// Receiver stall: random bursts, or a long counted hold-off.
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			out_stall <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else if (random_stall_en && $urandom_range(0, 4) == 0)
			out_stall <= 1'b1;
		else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("pedal_torque_curve_map_unit_tb NOT OK");
			$finish;
		end
	end

	// Deadzone edge, full scale, zero full scale, every mode including unused 3.
	task automatic test_directed();
		// Reset values: mode 0 gives zero.
		send_sample(16'd0);
		send_sample(16'hFFFF);
		wait_drained();
		set_curve(16'd1000, 16'd100, 16'd8192, 16'd65535, MODE_LINEAR, 16'd4096);
		send_sample(16'd100);
		send_sample(16'd101);
		send_sample(16'd600);
		send_sample(16'hFFFF);
		wait_drained();
		// Zero full scale counts as one; linear saturates.
		set_curve(16'd0, 16'd0, 16'hFFFF, 16'd65535, MODE_LINEAR, 16'd0);
		send_sample(16'd1);
		send_sample(16'hFFFF);
		wait_drained();
		set_curve(16'd65535, 16'd0, 16'd4096, 16'd65535, MODE_POWER, 16'd0);
		send_sample(16'd0);
		send_sample(16'd5000);
		wait_drained();
		write_reg(REG_EXPONENT, 32'd8192);
		send_sample(16'd0);
		send_sample(16'd1);
		send_sample(16'd32768);
		send_sample(16'hFFFF);
		wait_drained();
		write_reg(REG_EXPONENT, 32'hFFFF);
		send_sample(16'd1);
		send_sample(16'd40000);
		wait_drained();
		write_reg(REG_MODE, 32'd3);
		send_sample(16'd30000);
		send_sample(16'hFFFF);
		wait_drained();
		write_reg(REG_LIMIT, 32'd65534);
		write_reg(REG_MODE, 32'(MODE_LINEAR));
		send_sample(16'd65534);
		send_sample(16'hFFFF);
		wait_drained();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 10; ph++) begin
			set_curve(ph == 0 ? 16'd65535 : 16'($urandom_range(1, 65535)),
				16'($urandom_range(0, ph < 5 ? 2000 : 65534)),
				ph == 1 ? 16'hFFFF : 16'($urandom_range(4096, 65535)),
				16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
				ph == 2 ? 16'd0 : 16'($urandom_range(0, 65535)));
			if (ph % 3 != 0) write_reg(REG_MODE, 32'(MODE_POWER));
			for (int n = 0; n < 75; n++) send_sample(pick_sample());
			wait_drained();
		end
	endtask

	// Long receiver hold-off while samples keep coming, so in_stall rises.
	task automatic test_backpressure();
		set_curve(16'd40000, 16'd500, 16'd6000, 16'd30000, MODE_POWER, 16'd12288);
		hold_off_cycles = 60;
		for (int n = 0; n < 80; n++) send_sample(pick_sample());
		wait_drained();
	endtask

	// Last part: no idling on either side, back-to-back items.
	task automatic test_streaming();
		random_stall_en = 1'b0;
		input_gap_en = 1'b0;
		set_curve(16'd50000, 16'd200, 16'd5000, 16'd20000, MODE_LINEAR, 16'd4096);
		for (int n = 0; n < 60; n++) send_sample(16'($urandom));
		wait_drained();
		write_reg(REG_MODE, 32'(MODE_POWER));
		for (int n = 0; n < 60; n++) send_sample(16'($urandom));
		wait_drained();
	endtask

	initial begin
		fill_roms();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		random_stall_en = 1'b1;
		input_gap_en = 1'b1;
		test_directed();
		test_random_phases();
		test_backpressure();
		test_streaming();
		$display("covered all curve modes, deadzone edges, zero full scale, saturation,");
		$display("random register settings, idling and back-pressure: %0d items checked",
			result_count);
		if (mismatch_count == 0)
			$display("pedal_torque_curve_map_unit_tb OK");
		else
			$display("pedal_torque_curve_map_unit_tb NOT OK");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+src
src/ptcm_pkg.sv
src/ptcm_front.sv
src/ptcm_fifo.sv
src/ptcm_div.sv
src/ptcm_back.sv
src/pedal_torque_curve_map_unit.sv
src/ptcm_checker.sv
verif/pedal_torque_curve_map_unit_tb.sv
